>>> hdl/pcc_pkg.sv
// pcc_pkg: shared types and constants for the clamped pid controller
// register index codes and the per-word flags passed from front to back
// no dependencies
`default_nettype none

package pcc_pkg;

  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_KP_GAIN        = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KI_DT_GAIN     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KD_DIV_DT_GAIN = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_INTEGRAL_LIMIT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_LIMIT   = 3'd4;

  typedef struct packed {
    logic restart;
    logic first;
  } pcc_flags_t;

endpackage

`default_nettype wire

>>> hdl/pcc_fifo.sv
// pcc_fifo: small register queue with push/full and pop/empty sides
// used between front and back and on the result side
// no dependencies
`default_nettype none

module pcc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output      logic             full,
  input  wire logic             pop,
  output      logic [WIDTH-1:0] pop_data,
  output      logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW:0] FULL_COUNT = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             push_ok;
  logic             pop_ok;

  assign full     = (count == FULL_COUNT);
  assign empty    = (count == '0);
  assign push_ok  = push && !full;
  assign pop_ok   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        count <= count + 1'b1;
      end else if (pop_ok && !push_ok) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/pcc_front.sv
// pcc_front: accepts samples, forms the saturated error and error step
// tracks previous error and the first-sample flag; feeds the work queue
// depends on pcc_pkg
`default_nettype none

module pcc_front #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  output      logic                         full,
  input  wire logic signed [DATA_WIDTH-1:0] setpoint,
  input  wire logic signed [DATA_WIDTH-1:0] measured,
  input  wire logic                         restart,
  output      logic                         q_push,
  input  wire logic                         q_full,
  output      logic signed [DATA_WIDTH-1:0] q_error,
  output      logic signed [DATA_WIDTH-1:0] q_delta,
  output      pcc_pkg::pcc_flags_t          q_flags
);

  import pcc_pkg::*;

  localparam int W = DATA_WIDTH;
  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  logic signed [W-1:0] prev_error;
  logic                first_sample;
  logic signed [W:0]   err_wide;
  logic signed [W:0]   delta_wide;
  logic signed [W-1:0] err_sat;
  logic signed [W-1:0] delta_sat;
  logic                accept;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign q_push = accept;

  always_comb begin
    err_wide = {setpoint[W-1], setpoint} - {measured[W-1], measured};
    if (err_wide[W] != err_wide[W-1]) begin
      err_sat = err_wide[W] ? SMIN : SMAX;
    end else begin
      err_sat = err_wide[W-1:0];
    end
    delta_wide = {err_sat[W-1], err_sat} - {prev_error[W-1], prev_error};
    if (delta_wide[W] != delta_wide[W-1]) begin
      delta_sat = delta_wide[W] ? SMIN : SMAX;
    end else begin
      delta_sat = delta_wide[W-1:0];
    end
  end

  assign q_error         = err_sat;
  assign q_delta         = delta_sat;
  assign q_flags.restart = restart;
  assign q_flags.first   = first_sample || restart;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_sample <= 1'b1;
      prev_error   <= '0;
    end else if (accept) begin
      first_sample <= 1'b0;
      prev_error   <= err_sat;
    end
  end

endmodule

`default_nettype wire

>>> hdl/pcc_back.sv
// pcc_back: four-stage execution pipeline: gain products, scale and saturate,
// integrator update with clamp, output sum with clamp
// depends on pcc_pkg
`default_nettype none

module pcc_back #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic signed [DATA_WIDTH-1:0] kp_gain,
  input  wire logic signed [DATA_WIDTH-1:0] ki_dt_gain,
  input  wire logic signed [DATA_WIDTH-1:0] kd_div_dt_gain,
  input  wire logic        [DATA_WIDTH-2:0] integral_limit,
  input  wire logic        [DATA_WIDTH-2:0] output_limit,
  input  wire logic                         in_empty,
  output      logic                         in_pop,
  input  wire logic signed [DATA_WIDTH-1:0] in_ff,
  input  wire logic signed [DATA_WIDTH-1:0] in_error,
  input  wire logic signed [DATA_WIDTH-1:0] in_delta,
  input  wire pcc_pkg::pcc_flags_t          in_flags,
  output      logic                         out_push,
  input  wire logic                         out_full,
  output      logic signed [DATA_WIDTH-1:0] out_u,
  output      logic signed [DATA_WIDTH-1:0] out_p,
  output      logic signed [DATA_WIDTH-1:0] out_i,
  output      logic signed [DATA_WIDTH-1:0] out_d
);

  import pcc_pkg::*;

  localparam int W = DATA_WIDTH;
  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  function automatic logic signed [W-1:0] fx_sat(input logic signed [2*W-1:0] prod);
    logic signed [2*W-1:0] sh;
    logic                  fits;
    sh   = prod >>> FRAC_BITS;
    fits = (&sh[2*W-1:W-1]) || !(|sh[2*W-1:W-1]);
    if (fits) begin
      fx_sat = sh[W-1:0];
    end else begin
      fx_sat = sh[2*W-1] ? SMIN : SMAX;
    end
  endfunction

  logic adv;

  // stage 1: products
  logic                  s1_valid;
  logic signed [2*W-1:0] s1_prod_p;
  logic signed [2*W-1:0] s1_prod_i;
  logic signed [2*W-1:0] s1_prod_d;
  logic signed [W-1:0]   s1_ff;
  pcc_flags_t            s1_flags;

  // stage 2: scaled terms
  logic                s2_valid;
  logic signed [W-1:0] s2_p;
  logic signed [W-1:0] s2_inc;
  logic signed [W-1:0] s2_d;
  logic signed [W-1:0] s2_ff;
  logic                s2_restart;

  // stage 3: integrator
  logic                s3_valid;
  logic signed [W-1:0] integral_acc;
  logic signed [W-1:0] s3_p;
  logic signed [W-1:0] s3_d;
  logic signed [W-1:0] s3_ff;
  logic signed [W:0]   acc_sum;
  logic signed [W:0]   ilim;
  logic signed [W-1:0] acc_next;

  // stage 4: output sum
  logic                s4_valid;
  logic signed [W+1:0] u_sum;
  logic signed [W+1:0] olim;
  logic signed [W-1:0] u_next;

  assign adv    = !(s4_valid && out_full);
  assign in_pop = adv;
  assign out_push = s4_valid;

  always_comb begin
    ilim    = $signed({2'b00, integral_limit});
    acc_sum = (s2_restart ? '0 : {integral_acc[W-1], integral_acc})
              + {s2_inc[W-1], s2_inc};
    if (acc_sum > ilim) begin
      acc_next = ilim[W-1:0];
    end else if (acc_sum < -ilim) begin
      acc_next = W'(-ilim);
    end else begin
      acc_next = acc_sum[W-1:0];
    end
  end

  always_comb begin
    olim  = $signed({3'b000, output_limit});
    u_sum = {{2{s3_ff[W-1]}}, s3_ff} + {{2{s3_p[W-1]}}, s3_p}
            + {{2{integral_acc[W-1]}}, integral_acc} + {{2{s3_d[W-1]}}, s3_d};
    if (u_sum > olim) begin
      u_next = olim[W-1:0];
    end else if (u_sum < -olim) begin
      u_next = W'(-olim);
    end else begin
      u_next = u_sum[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_prod_p <= kp_gain * in_error;
      s1_prod_i <= ki_dt_gain * in_error;
      s1_prod_d <= kd_div_dt_gain * in_delta;
      s1_ff     <= in_ff;
      s1_flags  <= in_flags;

      s2_p       <= fx_sat(s1_prod_p);
      s2_inc     <= fx_sat(s1_prod_i);
      s2_d       <= s1_flags.first ? '0 : fx_sat(s1_prod_d);
      s2_ff      <= s1_ff;
      s2_restart <= s1_flags.restart;

      s3_p  <= s2_p;
      s3_d  <= s2_d;
      s3_ff <= s2_ff;

      out_u <= u_next;
      out_p <= s3_p;
      out_i <= integral_acc;
      out_d <= s3_d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      s4_valid     <= 1'b0;
      integral_acc <= '0;
    end else if (adv) begin
      s1_valid <= !in_empty;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      if (s2_valid) begin
        integral_acc <= acc_next;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/pid_controller_clamped.sv
// pid_controller_clamped: top level of the fixed-point pid controller
// with integrator and output clamps; holds the configuration registers
// depends on pcc_pkg, pcc_front, pcc_fifo, pcc_back
//
// Usage: samples enter on the push/full side; an input word is taken at a
// clock edge with push high and full low. Results leave on the empty/pop
// side; the oldest result sits on the output ports while empty is low and
// is taken at an edge with pop high. Gains and limits are written on the
// cfg channel (cfg_ready is always high); the user must write them only
// while the block is idle, which the block itself does not enforce.
// One word per cycle is sustained in both directions while pop keeps up.
// A word accepted into the work queue passes through registered steps:
// products while it sits in the work queue, then scaling, integrator,
// output sum and the write into the result queue.
// The integrator update and the previous error are the only loops.
// Reset clears the gains, limits, integrator, previous error and both
// queues, and marks the next sample as the first. When pop stays low the
// result queue fills, the back pipeline holds, the work queue fills and
// full rises; no word is dropped.
`default_nettype none

module pid_controller_clamped #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               push,
  output      logic                               full,
  input  wire logic signed [DATA_WIDTH-1:0]       setpoint,
  input  wire logic signed [DATA_WIDTH-1:0]       measured,
  input  wire logic signed [DATA_WIDTH-1:0]       feedforward,
  input  wire logic                               restart,
  output      logic                               empty,
  input  wire logic                               pop,
  output      logic signed [DATA_WIDTH-1:0]       control_out,
  output      logic signed [DATA_WIDTH-1:0]       p_term,
  output      logic signed [DATA_WIDTH-1:0]       i_term,
  output      logic signed [DATA_WIDTH-1:0]       d_term,
  input  wire logic                               cfg_valid,
  output      logic                               cfg_ready,
  input  wire logic [pcc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [DATA_WIDTH-1:0]              cfg_data
);

  import pcc_pkg::*;

  localparam int W       = DATA_WIDTH;
  localparam int FLAGS_W = $bits(pcc_flags_t);
  localparam int MID_W   = 3 * W + FLAGS_W;
  localparam int OUT_W   = 4 * W;
  localparam int QDEPTH  = 4;

  logic signed [W-1:0] kp_gain;
  logic signed [W-1:0] ki_dt_gain;
  logic signed [W-1:0] kd_div_dt_gain;
  logic [W-2:0]        integral_limit;
  logic [W-2:0]        output_limit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain        <= '0;
      ki_dt_gain     <= '0;
      kd_div_dt_gain <= '0;
      integral_limit <= '0;
      output_limit   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KP_GAIN:        kp_gain        <= cfg_data;
        REG_KI_DT_GAIN:     ki_dt_gain     <= cfg_data;
        REG_KD_DIV_DT_GAIN: kd_div_dt_gain <= cfg_data;
        REG_INTEGRAL_LIMIT: integral_limit <= cfg_data[W-2:0];
        REG_OUTPUT_LIMIT:   output_limit   <= cfg_data[W-2:0];
        default: ;
      endcase
    end
  end

  logic                f_push;
  logic                f_full;
  logic signed [W-1:0] f_error;
  logic signed [W-1:0] f_delta;
  pcc_flags_t          f_flags;

  pcc_front #(
    .DATA_WIDTH(W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .setpoint (setpoint),
    .measured (measured),
    .restart  (restart),
    .q_push   (f_push),
    .q_full   (f_full),
    .q_error  (f_error),
    .q_delta  (f_delta),
    .q_flags  (f_flags)
  );

  logic [MID_W-1:0] mid_wdata;
  logic [MID_W-1:0] mid_rdata;
  logic             mid_pop;
  logic             mid_empty;

  assign mid_wdata = {feedforward, f_error, f_delta, f_flags};

  pcc_fifo #(
    .WIDTH(MID_W),
    .DEPTH(QDEPTH)
  ) u_work_q (
    .clk       (clk),
    .rst       (rst),
    .push      (f_push),
    .push_data (mid_wdata),
    .full      (f_full),
    .pop       (mid_pop),
    .pop_data  (mid_rdata),
    .empty     (mid_empty)
  );

  logic signed [W-1:0] b_ff;
  logic signed [W-1:0] b_error;
  logic signed [W-1:0] b_delta;
  pcc_flags_t          b_flags;

  assign b_ff    = mid_rdata[MID_W-1 -: W];
  assign b_error = mid_rdata[MID_W-W-1 -: W];
  assign b_delta = mid_rdata[MID_W-2*W-1 -: W];
  assign b_flags = mid_rdata[FLAGS_W-1:0];

  logic                o_push;
  logic                o_full;
  logic signed [W-1:0] o_u;
  logic signed [W-1:0] o_p;
  logic signed [W-1:0] o_i;
  logic signed [W-1:0] o_d;

  pcc_back #(
    .DATA_WIDTH(W),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .kp_gain        (kp_gain),
    .ki_dt_gain     (ki_dt_gain),
    .kd_div_dt_gain (kd_div_dt_gain),
    .integral_limit (integral_limit),
    .output_limit   (output_limit),
    .in_empty       (mid_empty),
    .in_pop         (mid_pop),
    .in_ff          (b_ff),
    .in_error       (b_error),
    .in_delta       (b_delta),
    .in_flags       (b_flags),
    .out_push       (o_push),
    .out_full       (o_full),
    .out_u          (o_u),
    .out_p          (o_p),
    .out_i          (o_i),
    .out_d          (o_d)
  );

  logic [OUT_W-1:0] res_wdata;
  logic [OUT_W-1:0] res_rdata;

  assign res_wdata = {o_u, o_p, o_i, o_d};

  pcc_fifo #(
    .WIDTH(OUT_W),
    .DEPTH(QDEPTH)
  ) u_result_q (
    .clk       (clk),
    .rst       (rst),
    .push      (o_push),
    .push_data (res_wdata),
    .full      (o_full),
    .pop       (pop),
    .pop_data  (res_rdata),
    .empty     (empty)
  );

  assign control_out = res_rdata[4*W-1 -: W];
  assign p_term      = res_rdata[3*W-1 -: W];
  assign i_term      = res_rdata[2*W-1 -: W];
  assign d_term      = res_rdata[W-1:0];

endmodule

`default_nettype wire
